[rtl/fbgc_pkg.sv]
package fbgc_pkg;

   // Pixel layout: four 8-bit channels per 32-bit pixel.
   localparam int CHANNELS    = 4;
   localparam int CH_W        = 8;
   localparam int PIX_W       = CHANNELS * CH_W;
   localparam int NUM_STAGES  = 4;
   localparam int DEF_STAGES  = NUM_STAGES;

   // Pedestal removed and restored in extended range.
   localparam logic [CH_W-1:0] PEDESTAL = 8'h40;
   localparam logic [CH_W-1:0] CH_MAX   = 8'hFF;

   // Square root of a 16-bit value runs eight digit steps, four per stage.
   localparam int SQ_W = 2 * CH_W;
   localparam logic [3:0] TOP_SHIFT_HI = 4'd14;
   localparam logic [3:0] TOP_SHIFT_LO = 4'd6;
   localparam int STEPS_PER_STAGE = 4;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_LINEAR_MODE    = 2'd0,
      CSR_EXTENDED_RANGE = 2'd1,
      CSR_WRITE_BACK     = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   // Load enables for the four pipeline stages.
   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic s3_load;
      logic s4_load;
   } stage_en_type;

   // Partial square-root state: remainder and scaled root.
   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] root;
   } sqrt_state_type;

   // Four digit steps of the bitwise integer square root.
   function automatic sqrt_state_type sqrt_steps(sqrt_state_type s_in, logic [3:0] top_shift);
      sqrt_state_type s;
      logic [SQ_W-1:0] bitv;
      logic [SQ_W:0]   trial;
      s = s_in;
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
         bitv  = SQ_W'(1) << (top_shift - 4'(2 * i));
         trial = {1'b0, s.root} + {1'b0, bitv};
         if ({1'b0, s.rem} >= trial) begin
            s.rem  = s.rem - trial[SQ_W-1:0];
            s.root = (s.root >> 1) + bitv;
         end else begin
            s.root = s.root >> 1;
         end
      end
      return s;
   endfunction

endpackage

[rtl/fbgc_lane.sv]
module fbgc_lane
   import fbgc_pkg::*;
(
   input  logic            clock,
   input  stage_en_type    en,
   input  logic            linear_mode,
   input  logic            extended_range,
   input  logic [CH_W-1:0] cur_x,
   input  logic [CH_W-1:0] prev_y,
   output logic [CH_W-1:0] blend,
   output logic [CH_W-1:0] store
);

   logic            ext_on;
   logic [CH_W-1:0] x_adj;

   logic [SQ_W-1:0] sx_ff, sx_in;
   logic [SQ_W-1:0] sy_ff, sy_in;
   logic [CH_W-1:0] avg1_ff, avg1_in;
   logic [CH_W-1:0] avg2_ff, avg3_ff;
   logic [CH_W-1:0] st1_ff, st2_ff, st3_ff;

   logic [SQ_W:0]   w_sum;
   sqrt_state_type  s2_ff, s2_in;
   sqrt_state_type  s3_ff, s3_in;

   logic [CH_W:0]   r_round;
   logic [CH_W+1:0] r_ped;
   logic [CH_W-1:0] blend_ff, blend_in;
   logic [CH_W-1:0] store_ff;

   assign ext_on = linear_mode && extended_range;

   // Stage 1: pedestal removal, squares and the plain rounding average.
   always_comb begin
      if (ext_on) begin
         x_adj = (cur_x > PEDESTAL) ? (cur_x - PEDESTAL) : '0;
      end else begin
         x_adj = cur_x;
      end
      sx_in   = SQ_W'(x_adj) * SQ_W'(x_adj);
      sy_in   = SQ_W'(prev_y) * SQ_W'(prev_y);
      avg1_in = CH_W'(({1'b0, cur_x} + {1'b0, prev_y} + (CH_W+1)'(1)) >> 1);
   end

   always_ff @(posedge clock) begin
      if (en.s1_load) begin
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         avg1_ff <= avg1_in;
         st1_ff  <= x_adj;
      end
   end

   // Stage 2: mean of squares and the upper four root digits.
   always_comb begin
      w_sum = {1'b0, sx_ff} + {1'b0, sy_ff} + (SQ_W+1)'(1);
      s2_in = sqrt_steps('{rem: w_sum[SQ_W:1], root: '0}, TOP_SHIFT_HI);
   end

   always_ff @(posedge clock) begin
      if (en.s2_load) begin
         s2_ff   <= s2_in;
         avg2_ff <= avg1_ff;
         st2_ff  <= st1_ff;
      end
   end

   // Stage 3: the lower four root digits.
   assign s3_in = sqrt_steps(s2_ff, TOP_SHIFT_LO);

   always_ff @(posedge clock) begin
      if (en.s3_load) begin
         s3_ff   <= s3_in;
         avg3_ff <= avg2_ff;
         st3_ff  <= st2_ff;
      end
   end

   // Stage 4: round to nearest, restore the pedestal and pick the mode.
   // The remainder equals w - r*r, so rounding up is a compare with r.
   always_comb begin
      r_round = s3_ff.root[CH_W:0] + (CH_W+1)'(s3_ff.rem > s3_ff.root);
      r_ped   = {1'b0, r_round} + (CH_W+2)'(PEDESTAL);
      if (!linear_mode) begin
         blend_in = avg3_ff;
      end else if (extended_range) begin
         blend_in = (r_ped > (CH_W+2)'(CH_MAX)) ? CH_MAX : r_ped[CH_W-1:0];
      end else begin
         blend_in = r_round[CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4_load) begin
         blend_ff <= blend_in;
         store_ff <= st3_ff;
      end
   end

   assign blend = blend_ff;
   assign store = store_ff;

endmodule

[rtl/frame_blend_gamma_correct.sv]
// Blends a current-frame pixel with the stored previous-frame pixel, channel by channel,
// either as a rounding average or as a gamma-correct root-mean-square blend with an
// optional 0x40 pedestal, and also returns the value to write back to the blend store.
// An item is taken every clock when the output is not stalled; each item passes through
// the four-stage pipeline (squares, two stages of four square-root digits each, then
// rounding and pedestal restore). A stall on the result side holds the pipeline and
// fills empty stages first. Configuration writes are always taken and must be made only
// while no item is in flight.
module frame_blend_gamma_correct
   import fbgc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // Input item channel.
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [PIX_W-1:0] req_current_pixel,
   input  logic [PIX_W-1:0] req_previous_pixel,
   input  logic             req_last_in,
   // Result item channel.
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_blended_pixel,
   output logic [PIX_W-1:0] rsp_store_pixel,
   output logic             rsp_store_enable,
   output logic             rsp_last_out,
   // Configuration write channel.
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic             csr_data
);

   localparam int STAGES = NUM_STAGES;

   logic linear_mode_ff, extended_range_ff, write_back_ff;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] last_ff;
   logic [STAGES-1:0] wbe_ff;
   logic [STAGES-1:0] load;
   stage_en_type      en;

   // Configuration registers; writes are always accepted.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         linear_mode_ff    <= 1'b0;
         extended_range_ff <= 1'b0;
         write_back_ff     <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINEAR_MODE:    linear_mode_ff    <= csr_data;
            CSR_EXTENDED_RANGE: extended_range_ff <= csr_data;
            CSR_WRITE_BACK:     write_back_ff     <= csr_data;
            CSR_UNUSED:         ;
         endcase
      end
   end

   // A stage loads when it is empty or its contents move on.
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign req_stall = !load[0];

   assign en = '{s1_load: load[0], s2_load: load[1], s3_load: load[2], s4_load: load[3]};

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (load[k]) begin
               valid_ff[k] <= (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   // Side-band bits of each item follow the same stages.
   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (load[k]) begin
            if (k == 0) begin
               last_ff[k] <= req_last_in;
               wbe_ff[k]  <= write_back_ff;
            end else begin
               last_ff[k] <= last_ff[(k == 0) ? 0 : k - 1];
               wbe_ff[k]  <= wbe_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   // One datapath lane per channel.
   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      fbgc_lane u_lane (
         .clock          (clock),
         .en             (en),
         .linear_mode    (linear_mode_ff),
         .extended_range (extended_range_ff),
         .cur_x          (req_current_pixel[ch*CH_W +: CH_W]),
         .prev_y         (req_previous_pixel[ch*CH_W +: CH_W]),
         .blend          (rsp_blended_pixel[ch*CH_W +: CH_W]),
         .store          (rsp_store_pixel[ch*CH_W +: CH_W])
      );
   end

   assign rsp_valid        = valid_ff[STAGES-1];
   assign rsp_last_out     = last_ff[STAGES-1];
   assign rsp_store_enable = wbe_ff[STAGES-1];

endmodule
